FILE: src/sshd_pkg.sv
package sshd_pkg;

    localparam int HASH_W     = 32;
    localparam int COEFF_W    = 8;
    localparam int SLOT_W     = 5;
    localparam int FIRST_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_STEPS  = 3;

    // Remainder bits resolved in each reduction stage.
    localparam int RED_BITS   = 2;
    localparam int RED_STAGES = HASH_W / RED_BITS;

    localparam logic [HASH_W-1:0]  DEFAULT_MODULUS = HASH_W'(32749);
    localparam logic [FIRST_W-1:0] NO_SLOT         = FIRST_W'(32);

    localparam logic [CFG_IDX_W-1:0] REG_COEFF_ZERO  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_ONE   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_TWO   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_THREE = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = CFG_IDX_W'(4);

    typedef struct packed {
        logic [HASH_W-1:0]  mask;
        logic [FIRST_W-1:0] first;
    } t_item;

    typedef struct packed {
        logic               execute;
        logic [SLOT_W-1:0]  target;
        logic [FIRST_W-1:0] first;
    } t_result;

    // Isolate the lowest set bit, then encode the one-hot word with OR terms.
    function automatic logic [FIRST_W-1:0] lowest_set(input logic [HASH_W-1:0] m);
        logic [HASH_W-1:0]  onehot;
        logic [FIRST_W-1:0] idx;
        onehot = m & (~m + HASH_W'(1));
        idx    = '0;
        for (int i = 0; i < HASH_W; i++) begin
            if (onehot[i]) begin
                idx = idx | FIRST_W'(i);
            end
        end
        if (m == '0) begin
            idx = NO_SLOT;
        end
        return idx;
    endfunction

endpackage

FILE: src/schedule_slot_hash_decision.sv
// Schedule slot hash decision.
// Input channel: i_in_valid / o_in_stall with i_schedule_mask; a transfer happens
// at a rising edge where i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid / i_out_stall with o_execute, o_hash_slot and
// o_first_slot; the receiver takes a transfer when it holds i_out_stall low.
// Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
// (0..3 the byte coefficients, 4 the modulus); other indexes are ignored.
// Write only while no item is in flight.
// One item is accepted every cycle while o_in_stall is low. Each of the
// three Horner steps is one multiply-add stage followed by 16 remainder
// stages that resolve two bits each; these stages set the clock rate.
// Reset clears all valid bits and loads the coefficients with 0 and the
// modulus with 32749.
// When the receiver stalls, a skid register takes the next result; once it
// is full the whole pipeline holds and o_in_stall rises until it drains.
module schedule_slot_hash_decision (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [sshd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sshd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [sshd_pkg::HASH_W-1:0]     i_schedule_mask,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_execute,
    output logic [sshd_pkg::SLOT_W-1:0]     o_hash_slot,
    output logic [sshd_pkg::FIRST_W-1:0]    o_first_slot
);
    import sshd_pkg::*;

    localparam int LAST = RED_STAGES - 1;

    logic [COEFF_W-1:0] r_coeff_zero;
    logic [COEFF_W-1:0] r_coeff_one;
    logic [COEFF_W-1:0] r_coeff_two;
    logic [COEFF_W-1:0] r_coeff_three;
    logic [HASH_W-1:0]  r_modulus;

    // Multiply-add stage of each step.
    logic              r_mv [NUM_STEPS];
    logic [HASH_W-1:0] r_mt [NUM_STEPS];
    t_item             r_mi [NUM_STEPS];
    logic [HASH_W-1:0] n_mt [NUM_STEPS];
    t_item             n_mi [NUM_STEPS];
    logic              n_mv [NUM_STEPS];

    // Remainder stages of each step.
    logic              r_rv  [NUM_STEPS][RED_STAGES];
    logic [HASH_W-1:0] r_rem [NUM_STEPS][RED_STAGES];
    logic [HASH_W-1:0] r_rt  [NUM_STEPS][RED_STAGES];
    t_item             r_ri  [NUM_STEPS][RED_STAGES];
    logic [HASH_W-1:0] n_rem [NUM_STEPS][RED_STAGES];

    logic [HASH_W-1:0]  w_hash  [NUM_STEPS];
    logic [COEFF_W-1:0] w_coeff [NUM_STEPS];

    logic    w_en;
    logic    w_incoming;
    t_result w_res;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_zero  <= '0;
            r_coeff_one   <= '0;
            r_coeff_two   <= '0;
            r_coeff_three <= '0;
            r_modulus     <= DEFAULT_MODULUS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_COEFF_ZERO:  r_coeff_zero  <= i_cfg_data[COEFF_W-1:0];
                REG_COEFF_ONE:   r_coeff_one   <= i_cfg_data[COEFF_W-1:0];
                REG_COEFF_TWO:   r_coeff_two   <= i_cfg_data[COEFF_W-1:0];
                REG_COEFF_THREE: r_coeff_three <= i_cfg_data[COEFF_W-1:0];
                REG_MODULUS:     r_modulus     <= i_cfg_data[HASH_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_coeff[0] = r_coeff_two;
    assign w_coeff[1] = r_coeff_one;
    assign w_coeff[2] = r_coeff_zero;

    // The pipeline holds only while the skid register is occupied.
    assign w_en       = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    always_comb begin
        logic [HASH_W-1:0] acc;
        logic [HASH_W-1:0] prod;
        // A zero modulus means no reduction, so the wrapped sum passes through.
        for (int s = 0; s < NUM_STEPS; s++) begin
            w_hash[s] = (r_modulus == '0) ? r_rt[s][LAST] : r_rem[s][LAST];
        end
        for (int s = 0; s < NUM_STEPS; s++) begin
            if (s == 0) begin
                acc        = {{(HASH_W-COEFF_W){1'b0}}, r_coeff_three};
                n_mv[s]    = i_in_valid;
                n_mi[s]    = '{mask: i_schedule_mask, first: lowest_set(i_schedule_mask)};
            end else begin
                acc        = w_hash[s-1];
                n_mv[s]    = r_rv[s-1][LAST];
                n_mi[s]    = r_ri[s-1][LAST];
            end
            prod    = acc * n_mi[s].mask;
            n_mt[s] = prod + {{(HASH_W-COEFF_W){1'b0}}, w_coeff[s]};
        end
    end

    // Restoring remainder: each stage shifts in the next dividend bits and
    // subtracts the modulus whenever the partial remainder reaches it.
    always_comb begin
        logic [HASH_W:0]   rem;
        logic [HASH_W-1:0] t_in;
        for (int s = 0; s < NUM_STEPS; s++) begin
            for (int j = 0; j < RED_STAGES; j++) begin
                if (j == 0) begin
                    rem  = '0;
                    t_in = r_mt[s];
                end else begin
                    rem  = {1'b0, r_rem[s][j-1]};
                    t_in = r_rt[s][j-1];
                end
                for (int b = 0; b < RED_BITS; b++) begin
                    rem = {rem[HASH_W-1:0], t_in[HASH_W - 1 - j * RED_BITS - b]};
                    if (rem >= {1'b0, r_modulus}) begin
                        rem = rem - {1'b0, r_modulus};
                    end
                end
                n_rem[s][j] = rem[HASH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STEPS; s++) begin
                r_mv[s] <= 1'b0;
                for (int j = 0; j < RED_STAGES; j++) begin
                    r_rv[s][j] <= 1'b0;
                end
            end
        end else if (w_en) begin
            for (int s = 0; s < NUM_STEPS; s++) begin
                r_mv[s] <= n_mv[s];
                for (int j = 0; j < RED_STAGES; j++) begin
                    r_rv[s][j] <= (j == 0) ? r_mv[s] : r_rv[s][j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < NUM_STEPS; s++) begin
                r_mt[s] <= n_mt[s];
                r_mi[s] <= n_mi[s];
                for (int j = 0; j < RED_STAGES; j++) begin
                    r_rem[s][j] <= n_rem[s][j];
                    r_rt[s][j]  <= (j == 0) ? r_mt[s] : r_rt[s][j-1];
                    r_ri[s][j]  <= (j == 0) ? r_mi[s] : r_ri[s][j-1];
                end
            end
        end
    end

    always_comb begin
        w_res.target  = w_hash[NUM_STEPS-1][SLOT_W-1:0];
        w_res.first   = r_ri[NUM_STEPS-1][LAST].first;
        w_res.execute = (w_res.first == {1'b0, w_res.target});
    end

    assign w_incoming = w_en && r_rv[NUM_STEPS-1][LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid  <= r_skid_valid || w_incoming;
            r_skid_valid <= 1'b0;
        end else if (w_incoming) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_incoming) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_execute    = r_out.execute;
    assign o_hash_slot  = r_out.target;
    assign o_first_slot = r_out.first;

endmodule

FILE: test/testbench.sv
module testbench;
    import sshd_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 120;
    localparam int DRAIN_CYCLES   = 60;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_MODULUS + 1'b1;

    localparam logic [HASH_W-1:0] CORNER_MASKS [15] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
        32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF,
        32'h0001_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h4000_0000,
        32'h0000_0100, 32'h8000_0001, 32'h0000_001F
    };

    // Keeps its own copy of the registers and predicts the slot decision of
    // every mask transfer, in order.
    class slot_scoreboard;
        logic [COEFF_W-1:0] coeff [4];
        logic [HASH_W-1:0]  modulus;
        t_result            pending_decisions [$];
        int                 errors;

        function new();
            foreach (coeff[k]) coeff[k] = '0;
            modulus = DEFAULT_MODULUS;
            errors  = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_COEFF_ZERO:  coeff[0] = data[COEFF_W-1:0];
                REG_COEFF_ONE:   coeff[1] = data[COEFF_W-1:0];
                REG_COEFF_TWO:   coeff[2] = data[COEFF_W-1:0];
                REG_COEFF_THREE: coeff[3] = data[COEFF_W-1:0];
                REG_MODULUS:     modulus  = data;
                default: ;
            endcase
        endfunction

        // Multiply and add wrap at 32 bits; a zero modulus means no reduction.
        function logic [HASH_W-1:0] horner_step(input logic [HASH_W-1:0] acc,
                                                input logic [HASH_W-1:0] mask,
                                                input logic [COEFF_W-1:0] c);
            logic [HASH_W-1:0] sum;
            sum = acc * mask + HASH_W'(c);
            if (modulus != '0) begin
                sum = sum % modulus;
            end
            return sum;
        endfunction

        function void note_input(input logic [HASH_W-1:0] mask);
            logic [HASH_W-1:0] hash;
            t_result           want;
            hash = HASH_W'(coeff[3]);
            hash = horner_step(hash, mask, coeff[2]);
            hash = horner_step(hash, mask, coeff[1]);
            hash = horner_step(hash, mask, coeff[0]);
            want.first = NO_SLOT;
            for (int b = HASH_W - 1; b >= 0; b--) begin
                if (mask[b]) begin
                    want.first = FIRST_W'(b);
                end
            end
            want.target  = hash[SLOT_W-1:0];
            want.execute = (want.first == {1'b0, want.target});
            pending_decisions.push_back(want);
        endfunction

        function void check_result(input logic execute,
                                   input logic [SLOT_W-1:0] target,
                                   input logic [FIRST_W-1:0] first);
            t_result want;
            if (pending_decisions.size() == 0) begin
                $error("decision transfer with no mask pending");
                errors++;
                return;
            end
            want = pending_decisions.pop_front();
            if (execute !== want.execute) begin
                $error("execute: expected %0d, got %0d", want.execute, execute);
                errors++;
            end
            if (target !== want.target) begin
                $error("hash_slot: expected %0d, got %0d", want.target, target);
                errors++;
            end
            if (first !== want.first) begin
                $error("first_slot: expected %0d, got %0d", want.first, first);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [HASH_W-1:0]     i_schedule_mask;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_execute;
    logic [SLOT_W-1:0]     o_hash_slot;
    logic [FIRST_W-1:0]    o_first_slot;

    slot_scoreboard sb = new();
    int             burst_left = 0;

    schedule_slot_hash_decision i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_schedule_mask (i_schedule_mask),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_execute       (o_execute),
        .o_hash_slot     (o_hash_slot),
        .o_first_slot    (o_first_slot)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Mostly no gap, some short ones, a few long ones, and now and then a
    // burst of back-to-back transfers.
    function automatic int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Shifted masks move the lowest set bit around so that every slot and
    // the slot matches come up, not just slot zero.
    function automatic logic [HASH_W-1:0] random_mask();
        int                r;
        logic [HASH_W-1:0] m;
        r = $urandom_range(0, 99);
        m = $urandom;
        if (r < 8) return '0;
        if (r < 20) return HASH_W'(1) << $urandom_range(0, HASH_W - 1);
        if (r < 28) return {HASH_W{1'b1}} << $urandom_range(0, HASH_W - 1);
        if (r < 32) return {HASH_W{1'b1}};
        if (r < 70) return m << $urandom_range(0, HASH_W - 1);
        return m;
    endfunction

    task automatic send_mask(input logic [HASH_W-1:0] mask);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_schedule_mask <= mask;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(mask);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Coefficients go out with random upper bits, which must be dropped.
    // The write to an unused index comes last so that a wrong decode shows.
    task automatic program_regs(input logic [COEFF_W-1:0] c0, input logic [COEFF_W-1:0] c1,
                                input logic [COEFF_W-1:0] c2, input logic [COEFF_W-1:0] c3,
                                input logic [HASH_W-1:0] mod);
        logic [CFG_DATA_W-1:0] noise;
        noise = $urandom;
        write_reg(REG_COEFF_ZERO, {noise[CFG_DATA_W-1:COEFF_W], c0});
        noise = $urandom;
        write_reg(REG_COEFF_ONE, {noise[CFG_DATA_W-1:COEFF_W], c1});
        noise = $urandom;
        write_reg(REG_COEFF_TWO, {noise[CFG_DATA_W-1:COEFF_W], c2});
        noise = $urandom;
        write_reg(REG_COEFF_THREE, {noise[CFG_DATA_W-1:COEFF_W], c3});
        write_reg(REG_MODULUS, mod);
        write_reg(REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2)), $urandom);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_decisions.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [COEFF_W-1:0] c [4];
        logic [HASH_W-1:0]  mod;
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_schedule_mask <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values first: zero coefficients and the default modulus.
        foreach (CORNER_MASKS[k]) send_mask(CORNER_MASKS[k]);
        i_in_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            foreach (c[k]) c[k] = COEFF_W'($urandom);
            case (p)
                0: begin
                    foreach (c[k]) c[k] = '1;
                    mod = '1;
                end
                1: mod = '0;
                2: mod = HASH_W'(1);
                3: begin
                    foreach (c[k]) c[k] = '1;
                    mod = '0;
                end
                4: mod = HASH_W'(2);
                5: mod = DEFAULT_MODULUS;
                default: begin
                    case ($urandom_range(0, 2))
                        0: mod = HASH_W'($urandom_range(1, 64));
                        1: mod = $urandom;
                        default: mod = 32'h8000_0000 | $urandom;
                    endcase
                end
            endcase
            program_regs(c[0], c[1], c[2], c[3], mod);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Halfway through, hold off until the pipeline has emptied.
                if (i == PHASE_ITEMS / 2) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                end
                send_mask(random_mask());
            end
            i_in_valid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_decisions.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result side: takes transfers and stalls in runs of random length.
    initial begin
        int stall_run;
        int free_run;
        int r;
        stall_run = 0;
        free_run  = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_result(o_execute, o_hash_slot, o_first_slot);
            end
            if (stall_run > 0) begin
                stall_run--;
                i_out_stall <= 1'b1;
            end else if (free_run > 0) begin
                free_run--;
                i_out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    free_run = $urandom_range(1, 6);
                end else if (r < 80) begin
                    stall_run = $urandom_range(1, 3);
                end else if (r < 95) begin
                    free_run = $urandom_range(20, 100);
                end else begin
                    stall_run = $urandom_range(10, 50);
                end
                i_out_stall <= (stall_run > 0);
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAIL");
        $finish;
    end

endmodule
